// ----- rtl/pulse_rate_pd_speed_control_top_macros.svh -----
`ifndef PULSE_RATE_PD_SPEED_CONTROL_TOP_MACROS_SVH
`define PULSE_RATE_PD_SPEED_CONTROL_TOP_MACROS_SVH

// clocked check that is ignored while reset is high
`define PRPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define PRPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/prpd_pkg.sv -----
package prpd_pkg;

   localparam int CHANNELS    = 4;
   localparam int REPORTED    = 4;
   localparam int MASK_W      = 4;
   localparam int DRIVE_MAX   = 899;
   localparam int DRIVE_RESET = 699;
   localparam int DRIVE_W     = $clog2(DRIVE_MAX + 1);

   localparam int COUNT_W  = 16;
   localparam int SPEED_W  = 20;
   localparam int GAIN_W   = 14;
   localparam int ERR_W    = 21;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int PPROD_W  = GAIN_W + 1 + ERR_W;
   localparam int DPROD_W  = GAIN_W + 1 + DIFF_W;
   localparam int ACC_W    = DPROD_W + 1;
   localparam int FRAC_W   = 12;
   localparam int LVL_W    = ACC_W - FRAC_W + 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REQ_PULSE = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_FEEDBACK = 3'd0,
      REG_KP       = 3'd1,
      REG_KD       = 3'd2,
      REG_SP0      = 3'd3,
      REG_SP1      = 3'd4,
      REG_SP2      = 3'd5,
      REG_SP3      = 3'd6
   } reg_index_type;

   localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(614);
   localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(819);

   // pipeline strobes shared by all lanes
   typedef struct packed {
      logic pulse_acc;
      logic s1_load;
      logic s1_fb;
      logic s2_load;
      logic s3_load;
      logic s3_fb;
   } lane_ctrl_type;

endpackage

// ----- rtl/prpd_ctrl.sv -----
module prpd_ctrl
   import prpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_type,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic          fb_enable,
   output lane_ctrl_type ctrl
);

   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;
   logic s2_fb_ff, s2_fb_in;
   logic out_en, s2_en, s1_en;
   logic accept;

   assign out_en = !out_v_ff || rsp_ready;
   assign s2_en  = !s2_v_ff || out_en;
   assign s1_en  = !s1_v_ff || s2_en;

   assign req_ready = s1_en;
   assign rsp_valid = out_v_ff;
   assign accept    = req_valid && s1_en;

   always_comb begin
      ctrl.pulse_acc = accept && (req_type == REQ_PULSE);
      ctrl.s1_load   = accept && (req_type == REQ_TICK);
      ctrl.s1_fb     = fb_enable;
      ctrl.s2_load   = s1_v_ff && s2_en;
      ctrl.s3_load   = s2_v_ff && out_en;
      ctrl.s3_fb     = s2_fb_ff;
   end

   always_comb begin
      s1_v_in  = s1_v_ff;
      s2_v_in  = s2_v_ff;
      out_v_in = out_v_ff;
      s2_fb_in = s2_fb_ff;
      if (s1_en) begin
         s1_v_in = ctrl.s1_load;
      end
      if (s2_en) begin
         s2_v_in  = s1_v_ff;
         s2_fb_in = fb_enable;
      end
      if (out_en) begin
         out_v_in = s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         s2_fb_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
         s2_fb_ff <= s2_fb_in;
      end
   end

endmodule

// ----- rtl/prpd_lane.sv -----
module prpd_lane
   import prpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  logic                pulse,
   input  logic [SPEED_W-1:0]  setpoint,
   input  logic [GAIN_W-1:0]   kp,
   input  logic [GAIN_W-1:0]   kd,
   output logic [SPEED_W-1:0]  speed_out,
   output logic [DRIVE_W-1:0]  drive_out
);

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic [DRIVE_W-1:0]        drive_ff, drive_in;

   logic [SPEED_W-1:0]        speed1_ff, speed2_ff;
   logic signed [ERR_W-1:0]   err1_ff;
   logic signed [DIFF_W-1:0]  diff1_ff;
   logic signed [PPROD_W-1:0] pprod_ff;
   logic signed [DPROD_W-1:0] dprod_ff;

   logic [SPEED_W-1:0]        speed_now;
   logic signed [ERR_W-1:0]   err_now;
   logic signed [DIFF_W-1:0]  diff_now;
   logic signed [ACC_W-1:0]   acc;
   logic signed [LVL_W-1:0]   quot;
   logic                      round_up;
   logic signed [LVL_W-1:0]   lvl;
   logic [DRIVE_W-1:0]        clamped;

   // count times ten as two shifted copies
   assign speed_now = {1'b0, count_ff, 3'b000} + {3'b000, count_ff, 1'b0};
   assign err_now   = $signed({1'b0, speed_now}) - $signed({1'b0, setpoint});
   assign diff_now  = DIFF_W'(err_now) - DIFF_W'(prev_err_ff);

   always_comb begin
      count_in    = count_ff;
      prev_err_in = prev_err_ff;
      if (ctrl.s1_load) begin
         count_in = '0;
         if (ctrl.s1_fb) begin
            prev_err_in = err_now;
         end
      end else if (ctrl.pulse_acc && pulse && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // truncate toward zero: floor shift plus one for negative inexact sums
   assign acc      = ACC_W'(pprod_ff) + ACC_W'(dprod_ff);
   assign quot     = LVL_W'(acc >>> FRAC_W);
   assign round_up = acc[ACC_W-1] && (|acc[FRAC_W-1:0]);
   assign lvl      = $signed({{(LVL_W-DRIVE_W){1'b0}}, drive_ff}) + quot
                     + $signed({{(LVL_W-1){1'b0}}, round_up});

   always_comb begin
      if (lvl < 0) begin
         clamped = '0;
      end else if (lvl > LVL_W'(DRIVE_MAX)) begin
         clamped = DRIVE_W'(DRIVE_MAX);
      end else begin
         clamped = lvl[DRIVE_W-1:0];
      end
   end

   assign drive_in  = (ctrl.s3_load && ctrl.s3_fb) ? clamped : drive_ff;
   assign drive_out = ctrl.s3_fb ? clamped : drive_ff;
   assign speed_out = speed2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prev_err_ff <= '0;
         drive_ff    <= DRIVE_W'(DRIVE_RESET);
      end else begin
         count_ff    <= count_in;
         prev_err_ff <= prev_err_in;
         drive_ff    <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         speed1_ff <= speed_now;
         err1_ff   <= err_now;
         diff1_ff  <= diff_now;
      end
      if (ctrl.s2_load) begin
         speed2_ff <= speed1_ff;
         pprod_ff  <= $signed({1'b0, kp}) * err1_ff;
         dprod_ff  <= $signed({1'b0, kd}) * diff1_ff;
      end
   end

endmodule

// ----- rtl/pulse_rate_pd_speed_control_top.sv -----
// Four-channel encoder speed regulator with an incremental PD drive loop.
// Request channel (req_valid/req_ready): req_type selects a pulse beat, which
// adds one count to every channel marked in req_pulse_mask (saturating at
// 65535), or a window tick, which samples all counts as speeds (count times
// 10), clears them and, with feedback enabled, updates each drive level.
// Response channel (rsp_valid/rsp_ready): one beat per tick carrying the four
// speeds and the drive levels after the update. Pulse beats give no response.
// Throughput is one request beat per cycle, pulses and ticks alike, while
// req_ready is high. A tick's response passes the stages in order: the edge
// that accepts it stores error and difference, the middle stage stores the two
// gain products, and the output stage sums them, adds to the drive level,
// clamps and loads the output register. When rsp_ready is low the output
// holds; the two inner stages keep taking ticks until full, then req_ready
// drops. Pulse counting needs no stage. Reset clears counts and previous
// errors, sets each drive to 699, disables feedback and loads the default
// gains. The user must write the APB-style csr port only while no tick is in
// flight; the block does not enforce it. Reads return the stored registers.
module pulse_rate_pd_speed_control_top
   import prpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [MASK_W-1:0]     req_pulse_mask,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SPEED_W-1:0]    rsp_speed_ch0,
   output logic [SPEED_W-1:0]    rsp_speed_ch1,
   output logic [SPEED_W-1:0]    rsp_speed_ch2,
   output logic [SPEED_W-1:0]    rsp_speed_ch3,
   output logic [DRIVE_W-1:0]    rsp_drive_ch0,
   output logic [DRIVE_W-1:0]    rsp_drive_ch1,
   output logic [DRIVE_W-1:0]    rsp_drive_ch2,
   output logic [DRIVE_W-1:0]    rsp_drive_ch3,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic               fb_enable_ff, fb_enable_in;
   logic [GAIN_W-1:0]  kp_ff, kp_in;
   logic [GAIN_W-1:0]  kd_ff, kd_in;
   logic [SPEED_W-1:0] setpoint_ff [REPORTED];
   logic [SPEED_W-1:0] setpoint_in [REPORTED];

   logic               csr_wr;
   reg_index_type      csr_idx;
   lane_ctrl_type      ctrl;

   logic [SPEED_W-1:0] lane_speed [CHANNELS];
   logic [DRIVE_W-1:0] lane_drive [CHANNELS];
   logic [SPEED_W-1:0] speed_out_ff [REPORTED];
   logic [DRIVE_W-1:0] drive_out_ff [REPORTED];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      fb_enable_in = fb_enable_ff;
      kp_in        = kp_ff;
      kd_in        = kd_ff;
      setpoint_in  = setpoint_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_FEEDBACK: fb_enable_in   = csr_pwdata[0];
            REG_KP:       kp_in          = csr_pwdata[GAIN_W-1:0];
            REG_KD:       kd_in          = csr_pwdata[GAIN_W-1:0];
            REG_SP0:      setpoint_in[0] = csr_pwdata[SPEED_W-1:0];
            REG_SP1:      setpoint_in[1] = csr_pwdata[SPEED_W-1:0];
            REG_SP2:      setpoint_in[2] = csr_pwdata[SPEED_W-1:0];
            REG_SP3:      setpoint_in[3] = csr_pwdata[SPEED_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FEEDBACK: csr_prdata = CSR_DATA_W'(fb_enable_ff);
         REG_KP:       csr_prdata = CSR_DATA_W'(kp_ff);
         REG_KD:       csr_prdata = CSR_DATA_W'(kd_ff);
         REG_SP0:      csr_prdata = CSR_DATA_W'(setpoint_ff[0]);
         REG_SP1:      csr_prdata = CSR_DATA_W'(setpoint_ff[1]);
         REG_SP2:      csr_prdata = CSR_DATA_W'(setpoint_ff[2]);
         REG_SP3:      csr_prdata = CSR_DATA_W'(setpoint_ff[3]);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_enable_ff <= 1'b0;
         kp_ff        <= KP_RESET;
         kd_ff        <= KD_RESET;
         for (int r = 0; r < REPORTED; r++) begin
            setpoint_ff[r] <= '0;
         end
      end else begin
         fb_enable_ff <= fb_enable_in;
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         setpoint_ff  <= setpoint_in;
      end
   end

   prpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .fb_enable (fb_enable_ff),
      .ctrl      (ctrl)
   );

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic               lane_pulse;
      logic [SPEED_W-1:0] lane_setpoint;

      // channels beyond the mask and register set see no pulses and aim at zero
      assign lane_pulse    = (i < MASK_W) ? req_pulse_mask[i % MASK_W] : 1'b0;
      assign lane_setpoint = (i < REPORTED) ? setpoint_ff[i % REPORTED] : '0;

      prpd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .pulse     (lane_pulse),
         .setpoint  (lane_setpoint),
         .kp        (kp_ff),
         .kd        (kd_ff),
         .speed_out (lane_speed[i]),
         .drive_out (lane_drive[i])
      );
   end

   // merge stage: gather the lanes into the response register
   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         for (int r = 0; r < REPORTED; r++) begin
            if (r < CHANNELS) begin
               speed_out_ff[r] <= lane_speed[r % CHANNELS];
               drive_out_ff[r] <= lane_drive[r % CHANNELS];
            end else begin
               speed_out_ff[r] <= '0;
               drive_out_ff[r] <= '0;
            end
         end
      end
   end

   assign rsp_speed_ch0 = speed_out_ff[0];
   assign rsp_speed_ch1 = speed_out_ff[1];
   assign rsp_speed_ch2 = speed_out_ff[2];
   assign rsp_speed_ch3 = speed_out_ff[3];
   assign rsp_drive_ch0 = drive_out_ff[0];
   assign rsp_drive_ch1 = drive_out_ff[1];
   assign rsp_drive_ch2 = drive_out_ff[2];
   assign rsp_drive_ch3 = drive_out_ff[3];

endmodule

// ----- rtl/prpd_checker.sv -----
`include "pulse_rate_pd_speed_control_top_macros.svh"

module prpd_checker
   import prpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SPEED_W-1:0]    rsp_speed_ch0,
   input  logic [SPEED_W-1:0]    rsp_speed_ch1,
   input  logic [SPEED_W-1:0]    rsp_speed_ch2,
   input  logic [SPEED_W-1:0]    rsp_speed_ch3,
   input  logic [DRIVE_W-1:0]    rsp_drive_ch0,
   input  logic [DRIVE_W-1:0]    rsp_drive_ch1,
   input  logic [DRIVE_W-1:0]    rsp_drive_ch2,
   input  logic [DRIVE_W-1:0]    rsp_drive_ch3
);

   // a stalled response beat stays valid and keeps speed 0 and drives 0 and 3
   `PRPD_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_ch0)
         && $stable(rsp_drive_ch0) && $stable(rsp_drive_ch3),
      "response beat changed while stalled")

   // no response survives reset
   `PRPD_ASSERT_ALWAYS(a_rsp_reset, clock,
      $past(reset) |-> !rsp_valid,
      "response valid right after reset")

   // drive levels stay inside the clamp
   `PRPD_ASSERT(a_drive_range, clock, reset,
      rsp_valid |-> rsp_drive_ch0 <= DRIVE_W'(DRIVE_MAX)
         && rsp_drive_ch1 <= DRIVE_W'(DRIVE_MAX)
         && rsp_drive_ch2 <= DRIVE_W'(DRIVE_MAX)
         && rsp_drive_ch3 <= DRIVE_W'(DRIVE_MAX),
      "drive level above clamp")

   // speeds are whole multiples of ten, so bit zero is always clear
   `PRPD_ASSERT(a_speed_even, clock, reset,
      rsp_valid |-> !rsp_speed_ch0[0] && !rsp_speed_ch1[0]
         && !rsp_speed_ch2[0] && !rsp_speed_ch3[0],
      "odd speed value")

   // the request side never stalls while the pipe is drained
   `PRPD_ASSERT(a_ready_when_empty, clock, reset,
      !rsp_valid && $past(!rsp_valid) && $past(!req_valid, 2) && $past(!req_valid)
         |-> req_ready,
      "request stalled with empty pipe")

endmodule

bind pulse_rate_pd_speed_control_top prpd_checker u_prpd_checker (.*);
